// File: design/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Standalone header; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/modexp_pkg.sv
// Package for the modular exponentiation block: widths, register codes, FSM types.
// No dependencies; imported by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int CFG_IDX_W         = 1;

    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS      = 1'd0;
    localparam t_cfg_idx CFG_KEY_EXPONENT = 1'd1;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RED_GO,
        SEQ_RED_WAIT,
        SEQ_STEP,
        SEQ_ACC_GO,
        SEQ_ACC_WAIT,
        SEQ_SQ_GO,
        SEQ_SQ_WAIT,
        SEQ_DONE
    } t_seq_state;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_DBL,
        MUL_ADD,
        MUL_DONE
    } t_mul_state;

endpackage

// File: design/modexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, each multiplier bit taken by a double then an add phase.
// Depends on modexp_pkg and assert_macros.svh. Requires b < m and m >= 2.
module modexp_mulmod #(
    parameter int W = modexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_result
);
    import modexp_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(W);

    t_mul_state r_state, n_state;
    logic [W-1:0]     r_r, r_a, r_b, r_m;
    logic [CNT_W-1:0] r_cnt;

    logic [W-1:0] addend;
    logic [W:0]   sum;
    logic [W-1:0] red;

    // Shared add, compare and subtract: doubles r, then adds b when the top a bit is set.
    always_comb begin
        if (r_state == MUL_DBL) begin
            addend = r_r;
        end else if (r_a[W-1]) begin
            addend = r_b;
        end else begin
            addend = '0;
        end
        sum = {1'b0, r_r} + {1'b0, addend};
        if (sum >= {1'b0, r_m}) begin
            red = W'(sum - {1'b0, r_m});
        end else begin
            red = sum[W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            MUL_IDLE: begin
                if (i_start) n_state = MUL_DBL;
            end
            MUL_DBL:  n_state = MUL_ADD;
            MUL_ADD: begin
                if (r_cnt == '0) n_state = MUL_DONE;
                else             n_state = MUL_DBL;
            end
            MUL_DONE: n_state = MUL_IDLE;
            default:  n_state = MUL_IDLE;
        endcase
    end

    always_comb begin
        o_done   = (r_state == MUL_DONE);
        o_result = r_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MUL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MUL_IDLE: begin
                if (i_start) begin
                    r_r   <= '0;
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_m   <= i_m;
                    r_cnt <= CNT_W'(W - 1);
                end
            end
            MUL_DBL: begin
                r_r <= red;
            end
            MUL_ADD: begin
                // Advance to the next multiplier bit, most significant first.
                r_r   <= red;
                r_a   <= {r_a[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, r_state == MUL_IDLE, "start while busy")
    `ASSERT_IMPL(a_res_below_mod, i_clk, i_rst_n, o_done, r_r < r_m, "product not reduced")
    `ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_state == MUL_DBL, "start not taken")

endmodule

// File: design/modular_exponentiation.sv
// Channel    Dir  Handshake                 Payload
// input      in   i_in_valid / o_in_stall   i_base_value
// output     out  o_out_valid / i_out_stall o_power_result
// config     in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each item first reduces the base (base * 1 mod m), then per exponent bit
// does one squaring (skipped on the last bit) and, for a set bit, one
// multiply; each multiply runs on the single bit-serial mulmod unit. A
// modulus of one skips all multiplies and gives a result of zero.
// Synchronous active-low reset: modulus 1, exponent 0, no beat pending.
// Input stalls while an item is in work; a finished result waits in the
// output register and the next item is taken meanwhile.
//
// Depends on modexp_pkg, modexp_mulmod and assert_macros.svh.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  modexp_pkg::t_cfg_idx  i_cfg_index,
    input  modexp_pkg::t_field    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  modexp_pkg::t_field    i_base_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output modexp_pkg::t_field    o_power_result
);
    import modexp_pkg::*;
    `include "assert_macros.svh"

    localparam int W     = OPERAND_WIDTH;
    localparam int BIT_W = $clog2(W);

    t_seq_state r_state, n_state;

    logic [W-1:0]     r_modulus, r_exponent;
    logic [W-1:0]     r_base, r_sq, r_acc, r_exp_sh;
    logic [BIT_W-1:0] r_bit;
    logic [W-1:0]     r_out_data;
    logic             r_out_valid;

    logic [W-1:0] cfg_val;
    logic         in_acc, out_free, last_bit, mod_one;
    logic         mul_start, mul_done;
    logic [W-1:0] mul_a, mul_b, mul_res;

    assign cfg_val  = i_cfg_data[W-1:0];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_bit = (r_bit == BIT_W'(W - 1));
    assign mod_one  = (r_modulus == W'(1));

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_m      (r_modulus),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (in_acc) n_state = mod_one ? SEQ_DONE : SEQ_RED_GO;
            end
            SEQ_RED_GO: n_state = SEQ_RED_WAIT;
            SEQ_RED_WAIT: begin
                if (mul_done) n_state = SEQ_STEP;
            end
            SEQ_STEP: begin
                if (r_exp_sh[0])   n_state = SEQ_ACC_GO;
                else if (last_bit) n_state = SEQ_DONE;
                else               n_state = SEQ_SQ_GO;
            end
            SEQ_ACC_GO: n_state = SEQ_ACC_WAIT;
            SEQ_ACC_WAIT: begin
                if (mul_done) n_state = last_bit ? SEQ_DONE : SEQ_SQ_GO;
            end
            SEQ_SQ_GO: n_state = SEQ_SQ_WAIT;
            SEQ_SQ_WAIT: begin
                if (mul_done) n_state = SEQ_STEP;
            end
            SEQ_DONE: begin
                if (out_free) n_state = SEQ_IDLE;
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Outputs: handshake and mulmod operands
    always_comb begin
        o_in_stall = (r_state != SEQ_IDLE);
        mul_start  = 1'b0;
        mul_a      = r_sq;
        mul_b      = r_sq;
        case (r_state)
            SEQ_RED_GO: begin
                // base * 1 mod m reduces the base
                mul_start = 1'b1;
                mul_a     = r_base;
                mul_b     = W'(1);
            end
            SEQ_ACC_GO: begin
                mul_start = 1'b1;
                mul_b     = r_acc;
            end
            SEQ_SQ_GO: begin
                mul_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_modulus   <= W'(1);
            r_exponent  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODULUS: begin
                        // drop a zero modulus
                        if (cfg_val != '0) r_modulus <= cfg_val;
                    end
                    CFG_KEY_EXPONENT: r_exponent <= cfg_val;
                    default: begin
                    end
                endcase
            end
            if (r_state == SEQ_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SEQ_IDLE: begin
                if (in_acc) begin
                    r_base   <= i_base_value[W-1:0];
                    r_exp_sh <= r_exponent;
                    r_bit    <= '0;
                    r_acc    <= '0;
                end
            end
            SEQ_RED_WAIT: begin
                if (mul_done) begin
                    r_sq  <= mul_res;
                    r_acc <= W'(1);
                end
            end
            SEQ_ACC_WAIT: begin
                if (mul_done) r_acc <= mul_res;
            end
            SEQ_SQ_WAIT: begin
                // advance to the next exponent bit
                if (mul_done) begin
                    r_sq     <= mul_res;
                    r_exp_sh <= {1'b0, r_exp_sh[W-1:1]};
                    r_bit    <= r_bit + 1'b1;
                end
            end
            SEQ_DONE: begin
                if (out_free) r_out_data <= r_acc;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = t_field'(r_out_data);

    `ASSERT_IMPL(a_out_below_mod, i_clk, i_rst_n, r_out_valid, r_out_data < r_modulus, "result not reduced")
    `ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, mul_done, r_state == SEQ_RED_WAIT || r_state == SEQ_ACC_WAIT || r_state == SEQ_SQ_WAIT, "stray multiply done")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != SEQ_IDLE, "accepted beat not started")

endmodule
